FILE: rtl/sxf_pkg.sv
// sxf_pkg: request and response payload types, request codes and
// controller-to-datapath command struct for the sprite frame buffer
// no dependencies
package sxf_pkg;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_DRAW  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam int OUT_COLUMNS  = 64;
  localparam int SPRITE_WIDTH = 8;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [3:0] row_index;
    logic [7:0] sprite_byte;
    logic       last_row;
  } req_t;

  typedef struct packed {
    logic        collision;
    logic        sprite_done;
    logic [63:0] row_pixels;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

endpackage

FILE: rtl/sxf_ram.sv
// sxf_ram: generic single-write, single-read memory with registered read
// no dependencies
module sxf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/sxf_ctrl.sv
// sxf_ctrl: two-state controller, sequences request load and commit and
// owns the response valid flag; depends on sxf_pkg
module sxf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sxf_pkg::cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic rsp_valid_next;

  assign req_ready  = (state == ST_IDLE);
  assign cmd.load   = req_valid && req_ready;
  assign cmd.commit = (state == ST_EXEC) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd.commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.commit) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

FILE: rtl/sxf_datapath.sv
// sxf_datapath: coordinate wrap, row read-modify-write with xor and
// collision, row valid bits and response register; depends on sxf_pkg, sxf_ram
module sxf_datapath #(
  parameter int SCREEN_COLUMNS = 64,
  parameter int SCREEN_ROWS    = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  sxf_pkg::cmd_t cmd,
  input  sxf_pkg::req_t req,
  output sxf_pkg::rsp_t rsp
);

  localparam int CW = SCREEN_COLUMNS;
  localparam int AW = $clog2(SCREEN_ROWS);
  localparam int XW = $clog2(SCREEN_COLUMNS);
  localparam logic [8:0] COLS9 = 9'(SCREEN_COLUMNS);
  localparam logic [8:0] ROWS9 = 9'(SCREEN_ROWS);

  function automatic logic [7:0] wrap(input logic [7:0] v, input logic [8:0] m);
    logic [8:0] r;
    r = {1'b0, v};
    for (int i = 0; i < 8; i++) begin
      if (r >= m) begin
        r = r - m;
      end
    end
    return r[7:0];
  endfunction

  logic [7:0]    x_wrap;
  logic [7:0]    y_wrap;
  logic [8:0]    row_sum;
  logic [AW-1:0] rd_addr;

  logic [1:0]    req_type;
  logic          last_row;
  logic [7:0]    sprite_byte;
  logic [XW-1:0] col0;
  logic [AW-1:0] row_addr;
  logic          row_ok;

  logic [SCREEN_ROWS-1:0] row_valid;
  logic                   collision_pending;

  logic [CW-1:0] ram_rd_data;
  logic [CW-1:0] row_cur;
  logic [CW-1:0] mask;
  logic [CW-1:0] row_new;
  logic          hit;
  logic          is_draw;
  logic          ram_we;
  logic          coll_now;

  assign x_wrap  = wrap(req.x_pos, COLS9);
  assign y_wrap  = wrap(req.y_pos, ROWS9);
  assign row_sum = {1'b0, y_wrap} + {5'd0, req.row_index};

  always_comb begin
    if (req.req_type == sxf_pkg::REQ_DRAW) begin
      rd_addr = row_sum[AW-1:0];
    end else begin
      rd_addr = y_wrap[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type    <= req.req_type;
      last_row    <= req.last_row;
      sprite_byte <= req.sprite_byte;
      col0        <= x_wrap[XW-1:0];
      row_addr    <= rd_addr;
      row_ok      <= (row_sum < ROWS9);
    end
  end

  sxf_ram #(
    .WIDTH(CW),
    .DEPTH(SCREEN_ROWS)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(row_addr),
    .wr_data(row_new),
    .rd_en  (cmd.load),
    .rd_addr(rd_addr),
    .rd_data(ram_rd_data)
  );

  // rows never written since reset or clear read as all off
  assign row_cur  = row_valid[row_addr] ? ram_rd_data : '0;
  assign is_draw  = (req_type == sxf_pkg::REQ_DRAW);
  assign mask     = row_ok ? ({sprite_byte, {(CW - sxf_pkg::SPRITE_WIDTH){1'b0}}} >> col0)
                           : '0;
  assign hit      = |(row_cur & mask);
  assign row_new  = row_cur ^ mask;
  assign ram_we   = cmd.commit && is_draw && row_ok;
  assign coll_now = collision_pending || hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid         <= '0;
      collision_pending <= 1'b0;
    end else if (cmd.commit) begin
      if (req_type == sxf_pkg::REQ_CLEAR) begin
        row_valid         <= '0;
        collision_pending <= 1'b0;
      end else if (is_draw) begin
        collision_pending <= coll_now && !last_row;
        if (row_ok) begin
          row_valid[row_addr] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.collision   <= is_draw && coll_now;
      rsp.sprite_done <= is_draw && last_row;
      if (req_type == sxf_pkg::REQ_READ) begin
        rsp.row_pixels <= row_cur[CW-1 -: sxf_pkg::OUT_COLUMNS];
      end else begin
        rsp.row_pixels <= '0;
      end
    end
  end

endmodule

FILE: rtl/sprite_xor_framebuffer.sv
// sprite_xor_framebuffer: top level of the monochrome sprite frame buffer
// depends on sxf_pkg, sxf_ctrl, sxf_datapath, sxf_ram
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------
//   request | req_valid, req_ready | req (sxf_pkg::req_t)
//   result  | rsp_valid, rsp_ready | rsp (sxf_pkg::rsp_t)
//
// each request reads its row from the row memory when it is taken, then in its
// commit cycle modifies, writes back and loads the result register
// one result per request, in order; a waiting result holds the block in its
// commit cycle, while the next request can be taken as soon as it is committed
// clear and reset act at once through per-row valid bits, no clearing pass
module sprite_xor_framebuffer #(
  parameter int SCREEN_COLUMNS = 64,
  parameter int SCREEN_ROWS    = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sxf_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sxf_pkg::rsp_t rsp
);

  sxf_pkg::cmd_t cmd;

  sxf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .cmd      (cmd)
  );

  sxf_datapath #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .req(req),
    .rsp(rsp)
  );

endmodule

FILE: rtl/sxf_checker.sv
// sxf_checker: port-level checks on the sprite frame buffer, bound to the top
// depends on sxf_pkg
module sxf_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input sxf_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input sxf_pkg::rsp_t rsp
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while previous one in flight");

  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.row_pixels != 64'd0)) |-> (!rsp.collision && !rsp.sprite_done))
    else $error("row pixels mixed with draw flags");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result changed");

endmodule

bind sprite_xor_framebuffer sxf_checker u_sxf_checker (.*);

FILE: bench/tb.sv
// tb: self-checking bench for sprite_xor_framebuffer, with directed and random
// clear, draw and read requests checked against a behavioral frame buffer model
// depends on sxf_pkg and the sprite_xor_framebuffer rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = 64;
  localparam int ROWS = 32;
  localparam int TARGET_REQS = 1300;
  localparam int LONG_HOLD = 300;
  localparam int HOLD_AT = 500;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 10;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct {
    sxf_pkg::req_t payload;
    int unsigned   gap;
    bit            drain;
  } req_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  sxf_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  sxf_pkg::rsp_t rsp;

  sprite_xor_framebuffer #(
    .SCREEN_COLUMNS(COLS),
    .SCREEN_ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #10 clk = ~clk;

  // model state
  bit frame[ROWS][COLS];
  bit sprite_hit;

  req_entry_t    req_backlog[$];
  sxf_pkg::rsp_t fb_answers[$];

  int errors = 0;
  int reqs_sent = 0;
  int rsp_seen = 0;
  int sprites_done = 0;
  int collisions_seen = 0;
  int reads_seen = 0;
  int idle_cycles = 0;

  bit          tx_calm = 1'b0;
  bit          drain_next = 1'b0;
  req_entry_t  cur;
  bit          loaded = 1'b0;
  int unsigned gap_left = 0;
  logic        next_valid;

  bit          rx_calm = 1'b0;
  int unsigned stall_left = 0;
  logic        next_ready;

  function automatic sxf_pkg::rsp_t fb_apply(sxf_pkg::req_t r);
    sxf_pkg::rsp_t o;
    int col0;
    int row;
    int col;
    o = '0;
    case (r.req_type)
      sxf_pkg::REQ_CLEAR: begin
        foreach (frame[i, j]) frame[i][j] = 1'b0;
        sprite_hit = 1'b0;
      end
      sxf_pkg::REQ_DRAW: begin
        col0 = int'(r.x_pos) % COLS;
        row = int'(r.y_pos) % ROWS + int'(r.row_index);
        if (row < ROWS) begin
          for (int b = 0; b < 8; b++) begin
            col = col0 + b;
            if (col < COLS && r.sprite_byte[7 - b]) begin
              if (frame[row][col]) sprite_hit = 1'b1;
              frame[row][col] = !frame[row][col];
            end
          end
        end
        o.collision = sprite_hit;
        o.sprite_done = r.last_row;
        if (r.last_row) sprite_hit = 1'b0;
      end
      sxf_pkg::REQ_READ: begin
        row = int'(r.y_pos) % ROWS;
        for (int c = 0; c < 64 && c < COLS; c++) o.row_pixels[63 - c] = frame[row][c];
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic queue_req(logic [1:0] kind, int x, int y, int idx, int bits, bit last);
    req_entry_t e;
    e.payload.req_type = kind;
    e.payload.x_pos = x[7:0];
    e.payload.y_pos = y[7:0];
    e.payload.row_index = idx[3:0];
    e.payload.sprite_byte = bits[7:0];
    e.payload.last_row = last;
    e.gap = tx_calm ? 0 : $urandom_range(0, 19);
    e.drain = drain_next;
    drain_next = 1'b0;
    req_backlog.push_back(e);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      loaded = 1'b0;
      gap_left = 0;
    end else begin
      if (req_valid && req_ready) begin
        fb_answers.push_back(fb_apply(req));
        reqs_sent++;
      end
      if (!req_valid || req_ready) begin
        if (!loaded && req_backlog.size() > 0) begin
          cur = req_backlog.pop_front();
          loaded = 1'b1;
          gap_left = cur.gap;
        end
        next_valid = 1'b0;
        if (loaded) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (!(cur.drain && fb_answers.size() > 0)) begin
            next_valid = 1'b1;
            req <= cur.payload;
            loaded = 1'b0;
          end
        end
        req_valid <= next_valid;
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_left = 0;
    end else begin
      next_ready = rsp_ready;
      if (rsp_valid && rsp_ready) begin
        if (fb_answers.size() == 0) begin
          $error("result with no request outstanding: %h", rsp);
          errors++;
        end else begin
          automatic sxf_pkg::rsp_t exp = fb_answers.pop_front();
          if (rsp.collision !== exp.collision) begin
            $error("collision: expected %0d, got %0d", exp.collision, rsp.collision);
            errors++;
          end
          if (rsp.sprite_done !== exp.sprite_done) begin
            $error("sprite_done: expected %0d, got %0d", exp.sprite_done, rsp.sprite_done);
            errors++;
          end
          if (rsp.row_pixels !== exp.row_pixels) begin
            $error("row_pixels: expected %h, got %h", exp.row_pixels, rsp.row_pixels);
            errors++;
          end
          if (exp.sprite_done) sprites_done++;
          if (exp.collision) collisions_seen++;
          if (exp.row_pixels != 0) reads_seen++;
        end
        rsp_seen++;
        if (rsp_seen % 64 == 0) rx_calm = ($urandom_range(0, 2) == 0);
        if (rsp_seen == HOLD_AT) stall_left = LONG_HOLD;
        else stall_left = rx_calm ? 0 : $urandom_range(0, 19);
        next_ready = (stall_left == 0);
      end else if (!rsp_ready) begin
        if (stall_left > 0) stall_left--;
        if (stall_left == 0) next_ready = 1'b1;
      end
      rsp_ready <= next_ready;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int x;
    int y;
    int pick;
    int counted;
    int seg;
    bit drained_mid;

    counted = 0;
    seg = 0;
    drained_mid = 1'b0;

    // directed part
    queue_req(sxf_pkg::REQ_READ, 0, 0, 0, 0, 0);
    queue_req(sxf_pkg::REQ_READ, 0, 255, 0, 0, 0);
    queue_req(sxf_pkg::REQ_DRAW, 0, 0, 0, 8'hFF, 0);
    queue_req(sxf_pkg::REQ_DRAW, 0, 0, 0, 8'hFF, 1);
    queue_req(sxf_pkg::REQ_DRAW, 60, 0, 1, 8'hFF, 1);
    queue_req(sxf_pkg::REQ_DRAW, 255, 255, 0, 8'hAA, 1);
    queue_req(sxf_pkg::REQ_READ, 0, 1, 0, 0, 0);
    queue_req(sxf_pkg::REQ_READ, 0, 31, 0, 0, 0);
    queue_req(sxf_pkg::REQ_READ, 0, 63, 0, 0, 0);
    queue_req(sxf_pkg::REQ_DRAW, 8, 31, 0, 8'h81, 0);
    queue_req(sxf_pkg::REQ_DRAW, 8, 31, 0, 8'h80, 0);
    queue_req(sxf_pkg::REQ_DRAW, 8, 31, 15, 8'hFF, 1);
    queue_req(sxf_pkg::REQ_DRAW, 8, 31, 1, 8'hFF, 1);
    queue_req(sxf_pkg::REQ_DRAW, 128, 128, 15, 8'h00, 1);
    queue_req(REQ_UNKNOWN, 255, 255, 15, 8'hFF, 1);
    queue_req(sxf_pkg::REQ_READ, 0, 128, 0, 0, 0);
    queue_req(sxf_pkg::REQ_CLEAR, 255, 255, 15, 8'hFF, 1);
    queue_req(sxf_pkg::REQ_READ, 0, 0, 0, 0, 0);
    queue_req(sxf_pkg::REQ_READ, 0, 31, 0, 0, 0);
    queue_req(sxf_pkg::REQ_DRAW, 63, 31, 0, 8'h01, 1);
    queue_req(sxf_pkg::REQ_READ, 0, 31, 0, 0, 0);
    queue_req(REQ_UNKNOWN, 0, 0, 0, 0, 0);
    drain_next = 1'b1;
    queue_req(sxf_pkg::REQ_DRAW, 7, 3, 2, 8'h5A, 1);

    // random part
    while (counted < TARGET_REQS) begin
      if (counted / 60 != seg) begin
        seg = counted / 60;
        tx_calm = ($urandom_range(0, 3) == 0);
      end
      if (!drained_mid && counted > 700) begin
        drained_mid = 1'b1;
        drain_next = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        n = ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(1, 8);
        if ($urandom_range(0, 1)) begin
          x = $urandom_range(0, 7) * 8 + $urandom_range(0, 3);
          y = $urandom_range(0, 7) * 4;
        end else begin
          x = $urandom_range(0, 255);
          y = $urandom_range(0, 255);
        end
        for (int i = 0; i < n; i++) begin
          queue_req(sxf_pkg::REQ_DRAW, x, y, i, $urandom_range(0, 255), i == n - 1);
          counted++;
        end
      end else if (pick < 88) begin
        queue_req(sxf_pkg::REQ_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 1));
        counted++;
      end else if (pick < 91) begin
        queue_req(sxf_pkg::REQ_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 1));
        counted++;
      end else if (pick < 98) begin
        queue_req(sxf_pkg::REQ_DRAW, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 1));
        counted++;
      end else begin
        queue_req(REQ_UNKNOWN, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 1));
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (req_backlog.size() > 0 || loaded || req_valid || fb_answers.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d requests and %0d results checked: %0d sprites, %0d collisions reported",
             reqs_sent, rsp_seen, sprites_done, collisions_seen);
    $display("%0d nonzero row reads, one long receiver hold and two drained pauses",
             reads_seen);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
